/* hw/rtl/e2q_pkg.sv */
// Package: widths, constants and types shared by the Euler-to-quaternion block.
`default_nettype none
package e2q_pkg;

	localparam int CORDIC_ITERATIONS = 16;
	localparam int ATAN_TABLE_LEN    = 24;
	localparam int CORDIC_STAGES     =
		(CORDIC_ITERATIONS < ATAN_TABLE_LEN) ? CORDIC_ITERATIONS : ATAN_TABLE_LEN;

	localparam int CW        = 34;  // CORDIC datapath width, Q2.30 plus headroom
	localparam int MW        = 32;  // multiplier operand width
	localparam int PW        = 2 * MW;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef logic signed [15:0]   angle_t;
	typedef logic signed [15:0]   quat_t;
	typedef logic signed [CW-1:0] cw_t;
	typedef logic signed [MW-1:0] mw_t;
	typedef logic signed [PW-1:0] pw_t;

	localparam angle_t ANGLE_LIMIT = 16'sd25736;
	localparam angle_t ANGLE_FLOOR = -16'sd25736;
	localparam pw_t    Q14_ONE     = 64'sd16384;
	localparam pw_t    Q14_NEG_ONE = -64'sd16384;
	localparam cw_t    CORDIC_GAIN = 34'sd652032874;

	// atan(2^-i) in Q30
	localparam cw_t ATAN_Q30 [ATAN_TABLE_LEN] = '{
		34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
		34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
		34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
		34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
		34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
		34'sd1024,      34'sd512,       34'sd256,       34'sd128
	};

	typedef struct packed {
		angle_t roll_x;
		angle_t pitch_y;
		angle_t yaw_z;
	} angles_t;

endpackage
`default_nettype wire

/* hw/rtl/e2q_if.sv */
// Interfaces: valid/ready channels for angle words and quaternion words.
`default_nettype none
interface e2q_in_if;
	logic             valid;
	logic             ready;
	e2q_pkg::angle_t  roll_x;
	e2q_pkg::angle_t  pitch_y;
	e2q_pkg::angle_t  yaw_z;
	modport source (output valid, output roll_x, output pitch_y, output yaw_z, input ready);
	modport sink   (input valid, input roll_x, input pitch_y, input yaw_z, output ready);
endinterface

interface e2q_out_if;
	logic            valid;
	logic            ready;
	e2q_pkg::quat_t  quat_w;
	e2q_pkg::quat_t  quat_x;
	e2q_pkg::quat_t  quat_y;
	e2q_pkg::quat_t  quat_z;
	modport source (output valid, output quat_w, output quat_x, output quat_y,
		output quat_z, input ready);
	modport sink   (input valid, input quat_w, input quat_x, input quat_y,
		input quat_z, output ready);
endinterface
`default_nettype wire

/* hw/rtl/euler_to_quaternion_core.sv */
// Top level: Euler angles (ZYX) to unit quaternion, pipelined CORDIC.
// Takes roll/pitch/yaw words in signed Q3.13 radians (clamped to +-pi) and
// returns the unit quaternion q = qz*qy*qx as w, x, y, z in signed Q1.14,
// saturated to [-1, 1]. One word is accepted per clock and one result word
// leaves per clock while the output is not stalled; the path runs through
// the input queue, 16 micro-rotation stages, two multiply stages with
// rounding between, and the output register. A four-word queue separates the
// clamp front end from the back end; the back end advances whenever its
// output register is empty or taken. While a result waits the whole back
// end holds, and the queue keeps taking input until its four entries are
// full. No state is kept between words.
`default_nettype none
module euler_to_quaternion_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	e2q_in_if.sink     angles,
	e2q_out_if.source  quat
);

	logic             push_valid, push_ready, pop_valid, pop_ready;
	e2q_pkg::angles_t push_data, pop_data;

	e2q_front u_front (
		.angles     (angles),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_data  (push_data)
	);

	e2q_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	e2q_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.quat      (quat)
	);

endmodule
`default_nettype wire

/* hw/rtl/e2q_front.sv */
// Front end: accepts angle words and clamps each angle to +-pi.
`default_nettype none
module e2q_front (
	e2q_in_if.sink           angles,
	input  wire logic        push_ready,
	output logic             push_valid,
	output e2q_pkg::angles_t push_data
);

	function automatic e2q_pkg::angle_t clamp(input e2q_pkg::angle_t a);
		e2q_pkg::angle_t r;
		r = a;
		if (a > e2q_pkg::ANGLE_LIMIT) r = e2q_pkg::ANGLE_LIMIT;
		if (a < e2q_pkg::ANGLE_FLOOR) r = e2q_pkg::ANGLE_FLOOR;
		return r;
	endfunction

	assign angles.ready        = push_ready;
	assign push_valid          = angles.valid;
	assign push_data.roll_x    = clamp(angles.roll_x);
	assign push_data.pitch_y   = clamp(angles.pitch_y);
	assign push_data.yaw_z     = clamp(angles.yaw_z);

endmodule
`default_nettype wire

/* hw/rtl/e2q_queue.sv */
// Short queue between front end and CORDIC back end.
`default_nettype none
module e2q_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire e2q_pkg::angles_t push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output e2q_pkg::angles_t      pop_data
);

	e2q_pkg::angles_t                mem_q [e2q_pkg::QUEUE_DEPTH];
	logic [e2q_pkg::QUEUE_AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [e2q_pkg::QUEUE_AW:0]      count_q;
	logic                            push, pop;

	assign push_ready = (count_q != (e2q_pkg::QUEUE_AW+1)'(e2q_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (e2q_pkg::QUEUE_AW+1)'(e2q_pkg::QUEUE_DEPTH))
		else $error("queue count overflow");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q - rd_ptr_q) == count_q[e2q_pkg::QUEUE_AW-1:0])
		else $error("queue pointers disagree with count");
	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("push not counted");

endmodule
`default_nettype wire

/* hw/rtl/e2q_back.sv */
// Back end: three pipelined CORDIC lanes, ZYX product combine, output register.
`default_nettype none
module e2q_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             pop_valid,
	output logic                  pop_ready,
	input  wire e2q_pkg::angles_t pop_data,
	e2q_out_if.source             quat
);

	localparam int N    = e2q_pkg::CORDIC_STAGES;
	localparam int LAST = N + 4;

	// lane 0 = x (roll), 1 = y (pitch), 2 = z (yaw)
	e2q_pkg::cw_t x_s [N+1][3];
	e2q_pkg::cw_t y_s [N+1][3];
	e2q_pkg::cw_t z_s [N+1][3];
	logic [LAST:0] vld_q;
	logic          en;

	e2q_pkg::pw_t pair_s1 [4];   // czcy, szsy, czsy, szcy
	e2q_pkg::mw_t cx_s1, sx_s1, cx_s2, sx_s2;
	e2q_pkg::mw_t pair_s2 [4];
	e2q_pkg::pw_t tri_s3 [8];
	e2q_pkg::quat_t res_s4 [4];
	e2q_pkg::pw_t sum [4];

	assign en        = !vld_q[LAST] || quat.ready;
	assign pop_ready = en;

	function automatic e2q_pkg::cw_t z_init(input e2q_pkg::angle_t a);
		return {{2{a[15]}}, a, 16'd0};
	endfunction

	function automatic e2q_pkg::mw_t rnd_q30(input e2q_pkg::pw_t p);
		e2q_pkg::pw_t t;
		t = (p + (64'sd1 <<< 29)) >>> 30;
		return t[e2q_pkg::MW-1:0];
	endfunction

	function automatic e2q_pkg::quat_t to_q14(input e2q_pkg::pw_t s);
		e2q_pkg::pw_t v;
		v = (s + (64'sd1 <<< 45)) >>> 46;
		if (v > e2q_pkg::Q14_ONE)     v = e2q_pkg::Q14_ONE;
		if (v < e2q_pkg::Q14_NEG_ONE) v = e2q_pkg::Q14_NEG_ONE;
		return v[15:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAST-1:0], pop_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s[0][0] <= z_init(pop_data.roll_x);
			z_s[0][1] <= z_init(pop_data.pitch_y);
			z_s[0][2] <= z_init(pop_data.yaw_z);
			for (int l = 0; l < 3; l++) begin
				x_s[0][l] <= e2q_pkg::CORDIC_GAIN;
				y_s[0][l] <= '0;
			end
			// one micro-rotation per stage
			for (int i = 0; i < N; i++) begin
				for (int l = 0; l < 3; l++) begin
					if (!z_s[i][l][e2q_pkg::CW-1]) begin
						x_s[i+1][l] <= x_s[i][l] - (y_s[i][l] >>> i);
						y_s[i+1][l] <= y_s[i][l] + (x_s[i][l] >>> i);
						z_s[i+1][l] <= z_s[i][l] - e2q_pkg::ATAN_Q30[i];
					end else begin
						x_s[i+1][l] <= x_s[i][l] + (y_s[i][l] >>> i);
						y_s[i+1][l] <= y_s[i][l] - (x_s[i][l] >>> i);
						z_s[i+1][l] <= z_s[i][l] + e2q_pkg::ATAN_Q30[i];
					end
				end
			end
			// pair products, operands sign-extended so the full product is kept
			pair_s1[0] <= e2q_pkg::pw_t'(e2q_pkg::mw_t'(x_s[N][2])) *
				e2q_pkg::pw_t'(e2q_pkg::mw_t'(x_s[N][1]));
			pair_s1[1] <= e2q_pkg::pw_t'(e2q_pkg::mw_t'(y_s[N][2])) *
				e2q_pkg::pw_t'(e2q_pkg::mw_t'(y_s[N][1]));
			pair_s1[2] <= e2q_pkg::pw_t'(e2q_pkg::mw_t'(x_s[N][2])) *
				e2q_pkg::pw_t'(e2q_pkg::mw_t'(y_s[N][1]));
			pair_s1[3] <= e2q_pkg::pw_t'(e2q_pkg::mw_t'(y_s[N][2])) *
				e2q_pkg::pw_t'(e2q_pkg::mw_t'(x_s[N][1]));
			cx_s1 <= e2q_pkg::mw_t'(x_s[N][0]);
			sx_s1 <= e2q_pkg::mw_t'(y_s[N][0]);
			for (int k = 0; k < 4; k++) pair_s2[k] <= rnd_q30(pair_s1[k]);
			cx_s2 <= cx_s1;
			sx_s2 <= sx_s1;
			// triple products
			for (int k = 0; k < 4; k++) begin
				tri_s3[2*k]   <= e2q_pkg::pw_t'(pair_s2[k]) * e2q_pkg::pw_t'(cx_s2);
				tri_s3[2*k+1] <= e2q_pkg::pw_t'(pair_s2[k]) * e2q_pkg::pw_t'(sx_s2);
			end
			for (int k = 0; k < 4; k++) res_s4[k] <= to_q14(sum[k]);
		end
	end

	// tri index: 2k = pair k * cx, 2k+1 = pair k * sx
	assign sum[0] = tri_s3[0] + tri_s3[3];   // czcy*cx + szsy*sx
	assign sum[1] = tri_s3[1] - tri_s3[2];   // czcy*sx - szsy*cx
	assign sum[2] = tri_s3[4] + tri_s3[7];   // czsy*cx + szcy*sx
	assign sum[3] = tri_s3[6] - tri_s3[5];   // szcy*cx - czsy*sx

	assign quat.valid  = vld_q[LAST];
	assign quat.quat_w = res_s4[0];
	assign quat.quat_x = res_s4[1];
	assign quat.quat_y = res_s4[2];
	assign quat.quat_z = res_s4[3];

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved while stalled");
	a_take_on_en: assert property (@(posedge clk) disable iff (!arst_n)
		(en && pop_valid) |=> vld_q[0])
		else $error("popped word lost");
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid |-> (quat.quat_w <= 16'sd16384 && quat.quat_w >= -16'sd16384))
		else $error("quat_w out of range");

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
// Testbench for euler_to_quaternion_core: bit-exact prediction of each quaternion word.
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import e2q_pkg::*;

	// Sender and receiver idle rates in percent; one pair per phase.
	localparam int N_PHASES = 4;
	localparam int SRC_IDLE [N_PHASES] = '{0, 49, 0, 11};
	localparam int SNK_IDLE [N_PHASES] = '{0, 0, 49, 11};
	localparam int N_RANDOM = 1030;
	// Cycles without any word moving before the run is given up.
	localparam int STALL_LIMIT = 2000;
	// Pipeline depth plus margin, waited out at the end.
	localparam int DRAIN_CYCLES = CORDIC_STAGES + 20;

	typedef struct packed {
		quat_t w;
		quat_t x;
		quat_t y;
		quat_t z;
	} quat_word_t;

	logic clk;
	logic arst_n;

	e2q_in_if  angles ();
	e2q_out_if quat ();

	euler_to_quaternion_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.angles (angles.sink),
		.quat   (quat.source)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	angles_t    pending_angles [$];
	quat_word_t expected_quats [$];
	int         phase;
	int         errors = 0;
	int         idle_cycles = 0;
	logic       in_taken;

	// Floor division by 2^s; >>> on signed longint is arithmetic.
	function automatic longint floor_sh(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint round_sh(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	// Half-angle sine and cosine; the angle code read as Q2.14 is already halved.
	function automatic void half_angle_sincos(angle_t code, output longint c,
		output longint s);
		longint a;
		longint x;
		longint y;
		longint z;
		longint xs;
		longint ys;
		a = longint'(code);
		if (a > longint'(ANGLE_LIMIT))
			a = longint'(ANGLE_LIMIT);
		if (a < longint'(ANGLE_FLOOR))
			a = longint'(ANGLE_FLOOR);
		x = longint'(CORDIC_GAIN);
		y = 0;
		z = a * 65536;
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			xs = floor_sh(x, i);
			ys = floor_sh(y, i);
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - longint'(ATAN_Q30[i]);
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + longint'(ATAN_Q30[i]);
			end
		end
		c = x;
		s = y;
	endfunction

	// Q60 sum rounded to Q14 and saturated to +-1.
	function automatic quat_t q60_to_q14(longint v);
		longint r;
		r = round_sh(v, 46);
		if (r > 16384)
			r = 16384;
		if (r < -16384)
			r = -16384;
		return quat_t'(r);
	endfunction

	function automatic quat_word_t zyx_quaternion(angles_t a);
		longint cx, sx, cy, sy, cz, sz;
		longint czcy, szsy, czsy, szcy;
		quat_word_t q;
		half_angle_sincos(a.roll_x, cx, sx);
		half_angle_sincos(a.pitch_y, cy, sy);
		half_angle_sincos(a.yaw_z, cz, sz);
		czcy = round_sh(cz * cy, 30);
		szsy = round_sh(sz * sy, 30);
		czsy = round_sh(cz * sy, 30);
		szcy = round_sh(sz * cy, 30);
		q.w = q60_to_q14(czcy * cx + szsy * sx);
		q.x = q60_to_q14(czcy * sx - szsy * cx);
		q.y = q60_to_q14(czsy * cx + szcy * sx);
		q.z = q60_to_q14(szcy * cx - czsy * sx);
		return q;
	endfunction

	// Random angle: mostly in range, some raw 16-bit codes to hit the clamp
	// and every bit pattern.
	function automatic angle_t rand_angle();
		int r;
		r = $urandom_range(99);
		if (r < 75)
			return angle_t'($urandom_range(2 * 25736) - 25736);
		else if (r < 85)
			return angle_t'($urandom_range(25736 + 64, 25736 - 64)) *
				(($urandom_range(1) == 1) ? 16'sd1 : -16'sd1);
		else
			return angle_t'($urandom);
	endfunction

	// Driver: present the next word on the falling edge; hold while not taken.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angles.valid   <= 1'b0;
			angles.roll_x  <= '0;
			angles.pitch_y <= '0;
			angles.yaw_z   <= '0;
		end else if (!angles.valid || in_taken) begin
			// A word handed over at the last rising edge is already gone from
			// the queue; pick the next one or go idle.
			if (pending_angles.size() > 0 &&
				$urandom_range(99) >= SRC_IDLE[phase]) begin
				angles.valid   <= 1'b1;
				angles.roll_x  <= pending_angles[0].roll_x;
				angles.pitch_y <= pending_angles[0].pitch_y;
				angles.yaw_z   <= pending_angles[0].yaw_z;
			end else begin
				angles.valid <= 1'b0;
			end
		end
	end

	// Receiver ready, changed at the falling edge too.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n)
			quat.ready <= 1'b0;
		else
			quat.ready <= ($urandom_range(99) >= SNK_IDLE[phase]);
	end

	// Monitor: sample both channels at the rising edge.
	always @(posedge clk) begin
		angles_t    a;
		quat_word_t exp_q;
		bit         moved;
		moved = 1'b0;
		// ready may change after the edge, so the driver uses this flag
		in_taken <= angles.valid && angles.ready;
		if (arst_n) begin
			if (angles.valid && angles.ready) begin
				a = pending_angles.pop_front();
				expected_quats.push_back(zyx_quaternion(a));
				moved = 1'b1;
			end
			if (quat.valid && quat.ready) begin
				moved = 1'b1;
				if (expected_quats.size() == 0) begin
					$error("unexpected quaternion word w=%0d x=%0d y=%0d z=%0d",
						quat.quat_w, quat.quat_x, quat.quat_y, quat.quat_z);
					errors++;
				end else begin
					exp_q = expected_quats.pop_front();
					if (quat.quat_w !== exp_q.w) begin
						$error("quat_w: expected %0d, got %0d", exp_q.w, quat.quat_w);
						errors++;
					end
					if (quat.quat_x !== exp_q.x) begin
						$error("quat_x: expected %0d, got %0d", exp_q.x, quat.quat_x);
						errors++;
					end
					if (quat.quat_y !== exp_q.y) begin
						$error("quat_y: expected %0d, got %0d", exp_q.y, quat.quat_y);
						errors++;
					end
					if (quat.quat_z !== exp_q.z) begin
						$error("quat_z: expected %0d, got %0d", exp_q.z, quat.quat_z);
						errors++;
					end
				end
			end
			idle_cycles <= moved ? 0 : idle_cycles + 1;
		end
	end

	// Watchdog on cycles with no word moving.
	always @(posedge clk) begin
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	initial begin
		angles_t a;
		angle_t  edges [8];
		phase       = 0;
		arst_n      = 1'b0;
		edges = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd25737, -16'sd25737,
			16'sh7FFF, 16'sh8000, 16'sd12868};

		// Directed: zero, +-pi, clamp beyond pi, extreme codes, half pi per axis.
		for (int i = 0; i < 8; i++) begin
			a.roll_x  = edges[i];
			a.pitch_y = edges[(i + 3) % 8];
			a.yaw_z   = edges[(i + 5) % 8];
			pending_angles.push_back(a);
		end
		for (int i = 0; i < 8; i++) begin
			a = '0;
			a.roll_x  = (i % 3 == 0) ? edges[i] : 16'sd0;
			a.pitch_y = (i % 3 == 1) ? edges[i] : 16'sd0;
			a.yaw_z   = (i % 3 == 2) ? edges[i] : 16'sd0;
			pending_angles.push_back(a);
		end
		// Gimbal lock region: pitch at +-pi/2.
		a = '{16'sd3000, 16'sd12868, -16'sd7000};
		pending_angles.push_back(a);
		a = '{-16'sd20000, -16'sd12868, 16'sd22000};
		pending_angles.push_back(a);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int p = 0; p < N_PHASES; p++) begin
			phase = p;
			for (int i = 0; i < N_RANDOM / N_PHASES; i++) begin
				a.roll_x  = rand_angle();
				a.pitch_y = rand_angle();
				a.yaw_z   = rand_angle();
				pending_angles.push_back(a);
			end
			wait (pending_angles.size() == 0 && expected_quats.size() == 0);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
`default_nettype wire
